### hdl/htd_pkg.sv
`timescale 1ns / 1ps
package htd_pkg;

  localparam int NODES_DEF  = 512;
  localparam int LEAVES_DEF = 256;
  localparam int CMD_W      = 2;
  localparam int SYM_W      = 8;
  localparam int STAT_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_STEP   = 2'd1,
    CMD_SYMBOL = 2'd2,
    CMD_CODE   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_BADPATH   = 2'd2,
    ST_TOOMANY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_ISSUE,
    SQ_FINISH
  } seq_t;

  typedef struct packed {
    logic left;
    logic right;
    logic parent;
    logic leafb;
  } node_we_t;

  function automatic int idx_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

### hdl/htd_node_mem.sv
`timescale 1ns / 1ps
module htd_node_mem #(
  parameter int NODES = htd_pkg::NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic [htd_pkg::idx_w(NODES)-1:0] rd_addr,
  output logic [htd_pkg::idx_w(NODES)-1:0] rd_left,
  output logic [htd_pkg::idx_w(NODES)-1:0] rd_right,
  output logic [htd_pkg::idx_w(NODES)-1:0] rd_parent,
  output logic [htd_pkg::SYM_W-1:0]        rd_leafb,
  input  htd_pkg::node_we_t                we,
  input  logic [htd_pkg::idx_w(NODES)-1:0] wr_addr,
  input  logic [htd_pkg::idx_w(NODES)-1:0] wr_child,
  input  logic [htd_pkg::idx_w(NODES)-1:0] wr_parent,
  input  logic [htd_pkg::SYM_W-1:0]        wr_leafb
);
  import htd_pkg::*;

  localparam int NW = idx_w(NODES);

  logic [NW-1:0]    left_mem   [NODES];
  logic [NW-1:0]    right_mem  [NODES];
  logic [NW-1:0]    parent_mem [NODES];
  logic [SYM_W-1:0] leafb_mem  [NODES];

  always_ff @(posedge clk) begin
    if (we.left) begin
      left_mem[wr_addr] <= wr_child;
    end
    if (we.right) begin
      right_mem[wr_addr] <= wr_child;
    end
    if (we.parent) begin
      parent_mem[wr_addr] <= wr_parent;
    end
    if (we.leafb) begin
      leafb_mem[wr_addr] <= wr_leafb;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_left   <= left_mem[rd_addr];
      rd_right  <= right_mem[rd_addr];
      rd_parent <= parent_mem[rd_addr];
      rd_leafb  <= leafb_mem[rd_addr];
    end
  end

endmodule

### hdl/htd_order_mem.sv
`timescale 1ns / 1ps
module htd_order_mem #(
  parameter int NODES  = htd_pkg::NODES_DEF,
  parameter int LEAVES = htd_pkg::LEAVES_DEF
) (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [htd_pkg::idx_w(LEAVES)-1:0] rd_addr,
  output logic [htd_pkg::idx_w(NODES)-1:0]  rd_data,
  input  logic                              wr_en,
  input  logic [htd_pkg::idx_w(LEAVES)-1:0] wr_addr,
  input  logic [htd_pkg::idx_w(NODES)-1:0]  wr_data
);
  import htd_pkg::*;

  localparam int NW = idx_w(NODES);

  logic [NW-1:0] order_mem [LEAVES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      order_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= order_mem[rd_addr];
    end
  end

endmodule

### hdl/htd_ctrl.sv
`timescale 1ns / 1ps
module htd_ctrl #(
  parameter int NODES  = htd_pkg::NODES_DEF,
  parameter int LEAVES = htd_pkg::LEAVES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [htd_pkg::CMD_W-1:0]         in_command,
  input  logic                              in_bit_value,
  input  logic [htd_pkg::SYM_W-1:0]         in_symbol,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [htd_pkg::SYM_W-1:0]         out_decoded_symbol,
  output logic [htd_pkg::STAT_W-1:0]        out_status,
  output logic                              node_rd_en,
  output logic [htd_pkg::idx_w(NODES)-1:0]  node_rd_addr,
  input  logic [htd_pkg::idx_w(NODES)-1:0]  node_rd_left,
  input  logic [htd_pkg::idx_w(NODES)-1:0]  node_rd_right,
  input  logic [htd_pkg::idx_w(NODES)-1:0]  node_rd_parent,
  input  logic [htd_pkg::SYM_W-1:0]         node_rd_leafb,
  output htd_pkg::node_we_t                 node_we,
  output logic [htd_pkg::idx_w(NODES)-1:0]  node_wr_addr,
  output logic [htd_pkg::idx_w(NODES)-1:0]  node_wr_child,
  output logic [htd_pkg::idx_w(NODES)-1:0]  node_wr_parent,
  output logic [htd_pkg::SYM_W-1:0]         node_wr_leafb,
  output logic                              ord_rd_en,
  output logic [htd_pkg::idx_w(LEAVES)-1:0] ord_rd_addr,
  input  logic [htd_pkg::idx_w(NODES)-1:0]  ord_rd_data,
  output logic                              ord_wr_en,
  output logic [htd_pkg::idx_w(LEAVES)-1:0] ord_wr_addr,
  output logic [htd_pkg::idx_w(NODES)-1:0]  ord_wr_data
);
  import htd_pkg::*;

  localparam int NW = idx_w(NODES);
  localparam int LW = idx_w(LEAVES);
  localparam int CW = $clog2(LEAVES + 1);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
  localparam logic [CW-1:0] LEAF_CAP  = CW'(LEAVES);

  seq_t             seq_r, seq_nxt;
  cmd_t             cmd_r;
  logic             bit_r;
  logic [SYM_W-1:0] sym_r;

  logic [NW-1:0]    build_r, build_nxt;
  logic [NW-1:0]    free_r, free_nxt;
  logic             prev_r, prev_nxt;
  logic [CW-1:0]    rec_r, rec_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [NW-1:0]    walk_r, walk_nxt;
  logic             await_r, await_nxt;
  logic             above_r, above_nxt;
  logic [NW-1:0]    wleft_r, wleft_nxt;
  logic [NW-1:0]    wright_r, wright_nxt;
  logic [NW-1:0]    node_r, node_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [SYM_W-1:0] out_sym_r, out_sym_nxt;
  status_t          out_stat_r, out_stat_nxt;

  logic             slot_free, fin_go, in_take;
  logic             free_full, leaf_full, fill_empty, rd_is_leaf;
  logic [NW-1:0]    new_node, code_next;
  logic             res_vld;
  logic [SYM_W-1:0] res_sym;
  status_t          res_stat;

  assign slot_free  = !out_vld_r || !out_stall;
  assign fin_go     = (seq_r == SQ_FINISH) && slot_free;
  assign in_stall   = (seq_r == SQ_ISSUE) || ((seq_r == SQ_FINISH) && !slot_free);
  assign in_take    = in_valid && !in_stall;

  assign new_node   = free_r + NW'(1);
  assign free_full  = free_r == LAST_NODE;
  assign leaf_full  = rec_r == LEAF_CAP;
  assign fill_empty = fill_r >= rec_r;
  assign code_next  = bit_r ? wright_r : wleft_r;
  assign rd_is_leaf = (node_rd_left == '0) && (node_rd_right == '0);

  assign out_valid          = out_vld_r;
  assign out_decoded_symbol = out_sym_r;
  assign out_status         = out_stat_r;

  always_comb begin
    seq_nxt        = seq_r;
    build_nxt      = build_r;
    free_nxt       = free_r;
    prev_nxt       = prev_r;
    rec_nxt        = rec_r;
    fill_nxt       = fill_r;
    walk_nxt       = walk_r;
    await_nxt      = await_r;
    above_nxt      = above_r;
    wleft_nxt      = wleft_r;
    wright_nxt     = wright_r;
    node_nxt       = node_r;
    node_rd_en     = 1'b0;
    node_rd_addr   = '0;
    node_we        = '0;
    node_wr_addr   = '0;
    node_wr_child  = '0;
    node_wr_parent = build_r;
    node_wr_leafb  = '0;
    ord_rd_en      = 1'b0;
    ord_rd_addr    = fill_r[LW-1:0];
    ord_wr_en      = 1'b0;
    ord_wr_addr    = rec_r[LW-1:0];
    ord_wr_data    = build_r;
    res_vld        = 1'b0;
    res_sym        = '0;
    res_stat       = ST_OK;

    case (seq_r)
      SQ_IDLE: begin
        if (in_take) begin
          seq_nxt = SQ_ISSUE;
        end
      end
      SQ_ISSUE: begin
        seq_nxt = SQ_FINISH;
        case (cmd_r)
          CMD_STEP: begin
            if (!above_r) begin
              if (bit_r) begin
                node_rd_en   = 1'b1;
                node_rd_addr = build_r;
              end else if (!free_full) begin
                node_we.left  = !prev_r;
                node_we.right = prev_r;
                node_wr_addr  = build_r;
                node_wr_child = new_node;
              end
            end
          end
          CMD_SYMBOL: begin
            ord_rd_en = !fill_empty;
          end
          CMD_CODE: begin
            node_rd_en   = 1'b1;
            node_rd_addr = await_r ? '0 : code_next;
            node_nxt     = code_next;
          end
          default: begin
          end
        endcase
      end
      SQ_FINISH: begin
        if (fin_go) begin
          seq_nxt = in_take ? SQ_ISSUE : SQ_IDLE;
          case (cmd_r)
            CMD_BEGIN: begin
              build_nxt     = '0;
              free_nxt      = '0;
              prev_nxt      = 1'b0;
              rec_nxt       = '0;
              fill_nxt      = '0;
              above_nxt     = 1'b0;
              walk_nxt      = '0;
              await_nxt     = 1'b1;
              node_we.left  = 1'b1;
              node_we.right = 1'b1;
              node_we.leafb = 1'b1;
            end
            CMD_STEP: begin
              if (above_r) begin
                res_vld  = 1'b1;
                res_stat = ST_MALFORMED;
              end else if (bit_r) begin
                if (!prev_r && leaf_full) begin
                  res_vld  = 1'b1;
                  res_stat = ST_TOOMANY;
                end else begin
                  if (!prev_r) begin
                    ord_wr_en = 1'b1;
                    rec_nxt   = rec_r + CW'(1);
                  end
                  if (build_r == '0) begin
                    above_nxt = 1'b1;
                  end else begin
                    build_nxt = node_rd_parent;
                  end
                  prev_nxt = 1'b1;
                end
              end else if (free_full) begin
                res_vld  = 1'b1;
                res_stat = ST_TOOMANY;
              end else begin
                node_we.left   = 1'b1;
                node_we.right  = 1'b1;
                node_we.parent = 1'b1;
                node_we.leafb  = 1'b1;
                node_wr_addr   = new_node;
                free_nxt       = new_node;
                build_nxt      = new_node;
                prev_nxt       = 1'b0;
              end
            end
            CMD_SYMBOL: begin
              if (fill_empty) begin
                res_vld  = 1'b1;
                res_stat = ST_MALFORMED;
              end else begin
                node_we.leafb = 1'b1;
                node_wr_addr  = ord_rd_data;
                node_wr_leafb = sym_r;
                fill_nxt      = fill_r + CW'(1);
              end
            end
            CMD_CODE: begin
              if (await_r) begin
                walk_nxt = '0;
                if (rd_is_leaf) begin
                  res_vld = 1'b1;
                  res_sym = node_rd_leafb;
                end else begin
                  await_nxt  = 1'b0;
                  wleft_nxt  = node_rd_left;
                  wright_nxt = node_rd_right;
                end
              end else if (node_r == '0) begin
                res_vld   = 1'b1;
                res_stat  = ST_BADPATH;
                await_nxt = 1'b1;
                walk_nxt  = '0;
              end else begin
                walk_nxt   = node_r;
                wleft_nxt  = node_rd_left;
                wright_nxt = node_rd_right;
                if (rd_is_leaf) begin
                  res_vld   = 1'b1;
                  res_sym   = node_rd_leafb;
                  await_nxt = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        seq_nxt = SQ_IDLE;
      end
    endcase

    // keep the cached children of the walk node in step with the node store
    if (node_we.left && (node_wr_addr == walk_r)) begin
      wleft_nxt = node_wr_child;
    end
    if (node_we.right && (node_wr_addr == walk_r)) begin
      wright_nxt = node_wr_child;
    end

    out_vld_nxt  = out_vld_r;
    out_sym_nxt  = out_sym_r;
    out_stat_nxt = out_stat_r;
    if (slot_free) begin
      out_vld_nxt = res_vld;
    end
    if (res_vld) begin
      out_sym_nxt  = res_sym;
      out_stat_nxt = res_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= SQ_IDLE;
      build_r   <= '0;
      free_r    <= '0;
      prev_r    <= 1'b0;
      rec_r     <= '0;
      fill_r    <= '0;
      walk_r    <= '0;
      await_r   <= 1'b1;
      above_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      seq_r     <= seq_nxt;
      build_r   <= build_nxt;
      free_r    <= free_nxt;
      prev_r    <= prev_nxt;
      rec_r     <= rec_nxt;
      fill_r    <= fill_nxt;
      walk_r    <= walk_nxt;
      await_r   <= await_nxt;
      above_r   <= above_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= cmd_t'(in_command);
      bit_r <= in_bit_value;
      sym_r <= in_symbol;
    end
    wleft_r    <= wleft_nxt;
    wright_r   <= wright_nxt;
    node_r     <= node_nxt;
    out_sym_r  <= out_sym_nxt;
    out_stat_r <= out_stat_nxt;
  end

endmodule

### hdl/huffman_tree_load_and_decode_top.sv
`timescale 1ns / 1ps
// Huffman decoder with a tree loaded as a serialized walk. Send begin tree, then the step
// bits, then one symbol byte per recorded leaf, then code bits; each code word starts with
// one start bit that is skipped. A result item carries a decoded symbol or an error status
// (malformed tree, invalid code path, too many nodes or leaves) with symbol zero; items
// that finish silently produce nothing. Each item has an issue step, which presents the
// node store (or leaf order store) read, then a finish step, which acts on the registered
// read data and writes back. The children of the current code walk node are held in
// registers, so a code bit needs only the read of the next node. A new item is taken in
// the cycle the previous one completes, and not before; a result held by out_stall holds
// the item in its finish step. The node stores are not cleared by reset: issue begin tree
// before decoding.
module huffman_tree_load_and_decode_top #(
  parameter int NODES  = htd_pkg::NODES_DEF,
  parameter int LEAVES = htd_pkg::LEAVES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [htd_pkg::CMD_W-1:0] in_command,
  input  logic                      in_bit_value,
  input  logic [htd_pkg::SYM_W-1:0] in_symbol,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [htd_pkg::SYM_W-1:0] out_decoded_symbol,
  output logic [htd_pkg::STAT_W-1:0] out_status
);
  import htd_pkg::*;

  localparam int NW = idx_w(NODES);
  localparam int LW = idx_w(LEAVES);

  logic             node_rd_en;
  logic [NW-1:0]    node_rd_addr;
  logic [NW-1:0]    node_rd_left;
  logic [NW-1:0]    node_rd_right;
  logic [NW-1:0]    node_rd_parent;
  logic [SYM_W-1:0] node_rd_leafb;
  node_we_t         node_we;
  logic [NW-1:0]    node_wr_addr;
  logic [NW-1:0]    node_wr_child;
  logic [NW-1:0]    node_wr_parent;
  logic [SYM_W-1:0] node_wr_leafb;
  logic             ord_rd_en;
  logic [LW-1:0]    ord_rd_addr;
  logic [NW-1:0]    ord_rd_data;
  logic             ord_wr_en;
  logic [LW-1:0]    ord_wr_addr;
  logic [NW-1:0]    ord_wr_data;

  htd_node_mem #(
    .NODES(NODES)
  ) u_node_mem (
    .clk       (clk),
    .rd_en     (node_rd_en),
    .rd_addr   (node_rd_addr),
    .rd_left   (node_rd_left),
    .rd_right  (node_rd_right),
    .rd_parent (node_rd_parent),
    .rd_leafb  (node_rd_leafb),
    .we        (node_we),
    .wr_addr   (node_wr_addr),
    .wr_child  (node_wr_child),
    .wr_parent (node_wr_parent),
    .wr_leafb  (node_wr_leafb)
  );

  htd_order_mem #(
    .NODES (NODES),
    .LEAVES(LEAVES)
  ) u_order_mem (
    .clk     (clk),
    .rd_en   (ord_rd_en),
    .rd_addr (ord_rd_addr),
    .rd_data (ord_rd_data),
    .wr_en   (ord_wr_en),
    .wr_addr (ord_wr_addr),
    .wr_data (ord_wr_data)
  );

  htd_ctrl #(
    .NODES (NODES),
    .LEAVES(LEAVES)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_bit_value       (in_bit_value),
    .in_symbol          (in_symbol),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_decoded_symbol (out_decoded_symbol),
    .out_status         (out_status),
    .node_rd_en         (node_rd_en),
    .node_rd_addr       (node_rd_addr),
    .node_rd_left       (node_rd_left),
    .node_rd_right      (node_rd_right),
    .node_rd_parent     (node_rd_parent),
    .node_rd_leafb      (node_rd_leafb),
    .node_we            (node_we),
    .node_wr_addr       (node_wr_addr),
    .node_wr_child      (node_wr_child),
    .node_wr_parent     (node_wr_parent),
    .node_wr_leafb      (node_wr_leafb),
    .ord_rd_en          (ord_rd_en),
    .ord_rd_addr        (ord_rd_addr),
    .ord_rd_data        (ord_rd_data),
    .ord_wr_en          (ord_wr_en),
    .ord_wr_addr        (ord_wr_addr),
    .ord_wr_data        (ord_wr_data)
  );

endmodule

### hdl/htd_checker.sv
`timescale 1ns / 1ps
module htd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [htd_pkg::SYM_W-1:0]  out_decoded_symbol,
  input logic [htd_pkg::STAT_W-1:0] out_status
);
  import htd_pkg::*;

  a_two_cycle_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken in the cycle after an accepted item");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
    else $error("result appeared without an item taken three cycles earlier");

  a_error_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_decoded_symbol == '0)
    else $error("error result carries a nonzero symbol");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_decoded_symbol) && $stable(out_status))
    else $error("stalled result item changed");

endmodule

bind huffman_tree_load_and_decode_top htd_checker u_htd_checker (.*);
